@@ design/record_sort_by_average_desc_macros.svh @@
// ----------------------------------------------------------------------------
// record_sort_by_average_desc_macros
// assertion helpers shared by the record sort modules
// ----------------------------------------------------------------------------
`ifndef RECORD_SORT_BY_AVERAGE_DESC_MACROS_SVH
`define RECORD_SORT_BY_AVERAGE_DESC_MACROS_SVH

// property checked on every clock edge outside reset
`define RSAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define RSAD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ design/rsad_pkg.sv @@
// ----------------------------------------------------------------------------
// rsad_pkg
// shared types and constants of the record sort block
// ----------------------------------------------------------------------------
package rsad_pkg;

  localparam int MAX_RECORDS_DFLT = 32;
  localparam int SCORE_W          = 10;
  localparam int TAG_W            = 16;
  localparam int KEY_W            = 11;
  localparam int REC_W            = KEY_W + TAG_W;

  typedef struct packed {
    logic [SCORE_W-1:0] score_a;
    logic [SCORE_W-1:0] score_b;
    logic [TAG_W-1:0]   record_tag;
    logic               set_last;
  } rec_in_t;

  typedef struct packed {
    logic [TAG_W-1:0] out_tag;
    logic [KEY_W-1:0] average_twice;
    logic             is_best;
    logic             out_last;
    logic             overflowed;
  } rec_out_t;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic store;      // accept one input beat into the store
    logic cur_load;   // pivot register takes the read data
    logic step;       // compare pivot with read data, swap if smaller
    logic wb;         // write pivot back to its slot
    logic best_cur;   // best register takes the pivot
    logic best_rd;    // best register takes the read data
    logic out_best;   // load output register with the best entry
    logic out_rd;     // load output register with the read data
    logic item_last;  // the loaded sorted entry is the final one
    logic clear;      // set finished, drop count and overflow flag
  } rsad_cmd_t;

endpackage

@@ design/rsad_chan_if.sv @@
// ----------------------------------------------------------------------------
// rsad_chan_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface rsad_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ design/rsad_ram.sv @@
// ----------------------------------------------------------------------------
// rsad_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module rsad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/rsad_ctrl.sv @@
// ----------------------------------------------------------------------------
// rsad_ctrl
// sequencer: load, exchange sort passes, report of best and sorted list
// ----------------------------------------------------------------------------
module rsad_ctrl
  import rsad_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DFLT,
  localparam int AW    = $clog2(MAX_RECORDS),
  localparam int CNT_W = $clog2(MAX_RECORDS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_set_last,
  output logic             in_ready,
  input  logic             out_free,
  input  logic [CNT_W-1:0] count,
  output rsad_cmd_t        cmd,
  output logic [AW-1:0]    raddr,
  output logic [AW-1:0]    waddr
);

  localparam logic [2:0] ST_LOAD    = 3'd0;
  localparam logic [2:0] ST_RD_I    = 3'd1;
  localparam logic [2:0] ST_LD_I    = 3'd2;
  localparam logic [2:0] ST_CMP     = 3'd3;
  localparam logic [2:0] ST_WB      = 3'd4;
  localparam logic [2:0] ST_EM_BEST = 3'd5;
  localparam logic [2:0] ST_EM_LD   = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] k_r, k_nxt;

  logic [CNT_W-1:0] n_m1;
  logic [CNT_W-1:0] i_p1;
  logic [CNT_W-1:0] j_p1;
  logic [CNT_W-1:0] k_p1;

  assign n_m1 = count - CNT_W'(1);
  assign i_p1 = CNT_W'(i_r) + CNT_W'(1);
  assign j_p1 = CNT_W'(j_r) + CNT_W'(1);
  assign k_p1 = CNT_W'(k_r) + CNT_W'(1);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    cmd       = '0;
    raddr     = '0;
    waddr     = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.store = 1'b1;
          if (in_set_last) begin
            i_nxt     = '0;
            state_nxt = ST_RD_I;
          end
        end
      end
      ST_RD_I: begin
        raddr     = i_r;
        state_nxt = ST_LD_I;
      end
      ST_LD_I: begin
        cmd.cur_load = 1'b1;
        if (i_p1 == count) begin
          // single entry set, no sort needed
          cmd.best_rd = 1'b1;
          k_nxt       = '0;
          state_nxt   = ST_EM_BEST;
        end else begin
          raddr     = AW'(i_p1);
          j_nxt     = AW'(i_p1);
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.step = 1'b1;
        waddr    = j_r;
        if (CNT_W'(j_r) == n_m1) begin
          state_nxt = ST_WB;
        end else begin
          raddr = AW'(j_p1);
          j_nxt = AW'(j_p1);
        end
      end
      ST_WB: begin
        cmd.wb       = 1'b1;
        cmd.best_cur = (i_r == '0);
        waddr        = i_r;
        if (i_p1 == n_m1) begin
          k_nxt     = '0;
          state_nxt = ST_EM_BEST;
        end else begin
          raddr     = AW'(i_p1);
          i_nxt     = AW'(i_p1);
          state_nxt = ST_LD_I;
        end
      end
      ST_EM_BEST: begin
        raddr = '0;
        if (out_free) begin
          cmd.out_best = 1'b1;
          state_nxt    = ST_EM_LD;
        end
      end
      ST_EM_LD: begin
        raddr = k_r;
        if (out_free) begin
          cmd.out_rd    = 1'b1;
          cmd.item_last = (CNT_W'(k_r) == n_m1);
          if (CNT_W'(k_r) == n_m1) begin
            cmd.clear = 1'b1;
            state_nxt = ST_LOAD;
          end else begin
            raddr = AW'(k_p1);
            k_nxt = AW'(k_p1);
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

`include "record_sort_by_average_desc_macros.svh"

  `RSAD_ASSERT(a_j_range, state_r == ST_CMP |-> CNT_W'(j_r) < count && i_r < j_r, "bad sort index")
  `RSAD_ASSERT(a_hold_off, in_valid && in_ready && in_set_last |=> !in_ready, "input during sort")

endmodule

@@ design/rsad_dp.sv @@
// ----------------------------------------------------------------------------
// rsad_dp
// record store, pivot and best registers, key compare, output register
// ----------------------------------------------------------------------------
module rsad_dp
  import rsad_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DFLT,
  localparam int AW    = $clog2(MAX_RECORDS),
  localparam int CNT_W = $clog2(MAX_RECORDS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rsad_cmd_t        cmd,
  input  logic [AW-1:0]    raddr,
  input  logic [AW-1:0]    waddr,
  input  rec_in_t          in_data,
  output logic [CNT_W-1:0] count,
  output logic             out_free,
  input  logic             out_ready,
  output logic             out_valid,
  output rec_out_t         out_data
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [REC_W-1:0] cur_r;
  logic [REC_W-1:0] best_r;
  logic             out_vld_r, out_vld_nxt;
  rec_out_t         out_data_r;

  logic             full;
  logic             swap;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [REC_W-1:0] ram_wdata;
  logic [REC_W-1:0] rdata;
  logic [KEY_W-1:0] new_key;

  assign full    = (count_r >= CNT_W'(MAX_RECORDS));
  assign new_key = KEY_W'(in_data.score_a) + KEY_W'(in_data.score_b);
  assign swap    = (cur_r[REC_W-1:TAG_W] < rdata[REC_W-1:TAG_W]);

  always_comb begin
    ram_we    = (cmd.store && !full) || (cmd.step && swap) || cmd.wb;
    ram_waddr = cmd.store ? count_r[AW-1:0] : waddr;
    ram_wdata = cmd.store ? {new_key, in_data.record_tag} : cur_r;
  end

  rsad_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (cmd.clear) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (cmd.store) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  assign out_free = !out_vld_r || out_ready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.out_best || cmd.out_rd) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      ovf_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      ovf_r     <= ovf_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cur_load || (cmd.step && swap)) begin
      cur_r <= rdata;
    end
    if (cmd.best_rd) begin
      best_r <= rdata;
    end else if (cmd.best_cur) begin
      best_r <= cur_r;
    end
    if (cmd.out_best) begin
      out_data_r.out_tag       <= best_r[TAG_W-1:0];
      out_data_r.average_twice <= best_r[REC_W-1:TAG_W];
      out_data_r.is_best       <= 1'b1;
      out_data_r.out_last      <= 1'b0;
      out_data_r.overflowed    <= ovf_r;
    end else if (cmd.out_rd) begin
      out_data_r.out_tag       <= rdata[TAG_W-1:0];
      out_data_r.average_twice <= rdata[REC_W-1:TAG_W];
      out_data_r.is_best       <= 1'b0;
      out_data_r.out_last      <= cmd.item_last;
      out_data_r.overflowed    <= ovf_r;
    end
  end

  assign count     = count_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

`include "record_sort_by_average_desc_macros.svh"

  `RSAD_NEVER(a_cnt_cap, count_r > CNT_W'(MAX_RECORDS), "record count above capacity")
  `RSAD_NEVER(a_no_overwrite, (cmd.out_best || cmd.out_rd) && out_vld_r && !out_ready, "beat lost")

endmodule

@@ design/record_sort_by_average_desc.sv @@
// ----------------------------------------------------------------------------
// record_sort_by_average_desc
// collects a set of scored records, reports the best one and then the whole
// set sorted by descending score sum
// ----------------------------------------------------------------------------
// usage
//   in_ch: one beat per record (two scores, tag, set_last); ready is high only
//   while the block is collecting, one beat per cycle
//   out_ch: after the beat with set_last the block emits 1 + n beats, the
//   earliest highest-sum record marked is_best, then all n stored records in
//   descending order of score sum, the final one marked out_last
// capacity
//   MAX_RECORDS entries; further records of the set are dropped and every
//   reported beat of that set carries overflowed
// sort
//   the sort runs on one store port pair, one compare per cycle, n*(n-1)/2
//   compares in all; each pass ends by writing its pivot back to its slot
// reset and back pressure
//   synchronous active-low reset empties the set and the output register;
//   a stalled receiver freezes the report, the held beat stays on out_ch
// ----------------------------------------------------------------------------
module record_sort_by_average_desc
  import rsad_pkg::*;
#(
  parameter int MAX_RECORDS = MAX_RECORDS_DFLT
) (
  input logic  clk,
  input logic  rst_n,
  rsad_chan_if.sink   in_ch,
  rsad_chan_if.source out_ch
);

  localparam int AW    = $clog2(MAX_RECORDS);
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  // sequencer to datapath
  rsad_cmd_t        cmd;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  // datapath to sequencer
  logic [CNT_W-1:0] count;
  logic             out_free;

  rec_in_t          in_data;
  rec_out_t         out_data;

  assign in_data        = in_ch.payload;
  assign out_ch.payload = out_data;

  rsad_ctrl #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_set_last (in_data.set_last),
    .in_ready    (in_ch.ready),
    .out_free    (out_free),
    .count       (count),
    .cmd         (cmd),
    .raddr       (raddr),
    .waddr       (waddr)
  );

  rsad_dp #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .raddr     (raddr),
    .waddr     (waddr),
    .in_data   (in_data),
    .count     (count),
    .out_free  (out_free),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_data)
  );

endmodule
